>>> sv/assert_macros.svh
// Assertion macros shared by the tile corner angle RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_AT(label, prop, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

>>> sv/tcac_pkg.sv
// Types and constants of the tile corner angle pipeline.
// No dependencies.
package tcac_pkg;
  localparam int POS_W        = 24;
  localparam int TILE_W       = 11;
  localparam int HEAD_W       = 19;
  localparam int RAD_W        = 23;
  localparam int DIST_W       = 19;
  localparam int ANG_W        = 19;
  localparam int HEAD_FRAC    = 8;
  localparam int ZW           = 36;
  localparam int CORDIC_GUARD = 24;
  localparam int ATAN_TAB_LEN = 24;
  localparam int LANES        = 4;

  localparam logic [TILE_W-1:0] TILE_RESET = 11'd64;
  localparam logic [TILE_W-1:0] TILE_MAX   = 11'd1024;

  localparam logic signed [HEAD_W:0] FULL_DEG  = 20'sd92160;
  localparam logic signed [HEAD_W:0] HALF_DEG  = 20'sd46080;
  localparam logic signed [HEAD_W:0] QUART_DEG = 20'sd23040;
  localparam logic signed [HEAD_W:0] THREEQ_DEG = 20'sd69120;

  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  localparam logic signed [ZW-1:0] QUARTER_Q32 = 36'sd6746518852;
  localparam logic [ZW-1:0] QUAD_OFF [LANES] = '{
    36'd0, 36'd6746518852, 36'd13493037704, 36'd20239556557
  };

  localparam logic [31:0] ATAN_TAB [ATAN_TAB_LEN] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635, 32'd268086748,
    32'd134174063, 32'd67103403, 32'd33553749, 32'd16777131, 32'd8388597,
    32'd4194303, 32'd2097152, 32'd1048576, 32'd524288, 32'd262144, 32'd131072,
    32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512
  };

  localparam logic [ANG_W-1:0] ANGLE_MAX = 19'd411775;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    logic signed [RAD_W-1:0]  rad;
    logic [DIST_W-1:0]        d_top;
    logic [DIST_W-1:0]        d_bot;
    logic [DIST_W-1:0]        d_left;
    logic [DIST_W-1:0]        d_right;
    logic [LANES-1:0]         num_zero;
    logic [LANES-1:0]         den_zero;
  } side_t;
endpackage

>>> sv/tcac_mod_cell.sv
// One restoring step of the tile remainder chain, one position bit per cell.
// Depends on tcac_pkg.
module tcac_mod_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk_i,
  input  logic [tcac_pkg::TILE_W-1:0] tile_i,
  input  logic [tcac_pkg::POS_W-1:0]  pos_i,
  input  logic [tcac_pkg::TILE_W-1:0] rem_i,
  output logic [tcac_pkg::POS_W-1:0]  pos_o,
  output logic [tcac_pkg::TILE_W-1:0] rem_o
);
  import tcac_pkg::*;

  logic [TILE_W:0]   trial;
  logic [TILE_W:0]   rem_d;
  logic [TILE_W-1:0] rem_q;
  logic [POS_W-1:0]  pos_q;

  always_comb begin
    trial = {rem_i, pos_i[POS_W-1-IDX]};
    rem_d = (trial >= {1'b0, tile_i}) ? trial - {1'b0, tile_i} : trial;
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_i;
    rem_q <= rem_d[TILE_W-1:0];
  end

  assign pos_o = pos_q;
  assign rem_o = rem_q;
endmodule

>>> sv/tcac_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its registers.
// Depends on tcac_pkg for the arctangent table.
module tcac_cordic_cell #(
  parameter int IDX = 0,
  parameter int XW  = 46
) (
  input  logic                           clk_i,
  input  logic signed [XW-1:0]           x_i,
  input  logic signed [XW-1:0]           y_i,
  input  logic signed [tcac_pkg::ZW-1:0] z_i,
  output logic signed [XW-1:0]           x_o,
  output logic signed [XW-1:0]           y_o,
  output logic signed [tcac_pkg::ZW-1:0] z_o
);
  import tcac_pkg::*;

  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] step, z_d, z_q;

  always_comb begin
    dx   = y_i >>> IDX;
    dy   = x_i >>> IDX;
    step = $signed({4'b0, ATAN_TAB[IDX]});
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + step;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - step;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

>>> sv/tile_corner_angle_calc.sv
// Top level: heading normalize, tile remainder chain, four CORDIC cell rows.
// Depends on tcac_pkg, tcac_mod_cell, tcac_cordic_cell and assert_macros.svh.
//
//  channel  | signals                                        | direction
//  item in  | start, busy, pos_x_i, pos_y_i, heading_deg_i   | in
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_data_i           | in
//  result   | done_o and the result ports                    | out
//
// One item per cycle while busy is low; each item runs through the remainder cell
// chain (one position bit per cell) and the CORDIC rows.
// busy is high for one cycle after reset, then stays low.
// Results carry no back-pressure; done_o marks each result for one cycle.
`include "assert_macros.svh"
module tile_corner_angle_calc #(
  parameter int POS_FRAC_BITS   = 8,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcac_pkg::TILE_W-1:0]         cfg_data_i,
  input  logic [tcac_pkg::POS_W-1:0]          pos_x_i,
  input  logic [tcac_pkg::POS_W-1:0]          pos_y_i,
  input  logic signed [tcac_pkg::HEAD_W-1:0]  heading_deg_i,
  output logic                                done_o,
  output logic signed [tcac_pkg::HEAD_W-1:0]  heading_norm_o,
  output logic signed [tcac_pkg::RAD_W-1:0]   heading_rad_o,
  output logic [tcac_pkg::DIST_W-1:0]         dist_top_o,
  output logic [tcac_pkg::DIST_W-1:0]         dist_bottom_o,
  output logic [tcac_pkg::DIST_W-1:0]         dist_left_o,
  output logic [tcac_pkg::DIST_W-1:0]         dist_right_o,
  output logic [tcac_pkg::ANG_W-1:0]          angle_top_right_o,
  output logic [tcac_pkg::ANG_W-1:0]          angle_top_left_o,
  output logic [tcac_pkg::ANG_W-1:0]          angle_bottom_left_o,
  output logic [tcac_pkg::ANG_W-1:0]          angle_bottom_right_o
);
  import tcac_pkg::*;

  localparam int IW  = POS_W - POS_FRAC_BITS;
  localparam int DW  = TILE_W + POS_FRAC_BITS;
  localparam int XW  = DW + CORDIC_GUARD + 3;
  localparam int RS  = 32 + HEAD_FRAC - ANGLE_FRAC_BITS;
  localparam int AS  = 32 - ANGLE_FRAC_BITS;
  localparam int LAT = IW + CORDIC_STAGES + 3;
  localparam logic [POS_W-1:0] FRAC_MASK = POS_W'((64'd1 << POS_FRAC_BITS) - 64'd1);

  logic               busy_q;
  logic [TILE_W-1:0]  tile_q;
  logic [TILE_W-1:0]  tl;
  logic               accept;
  logic [LAT-1:0]     vld_q;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign done_o      = vld_q[LAT-1];

  always_comb begin
    if (tile_q == '0) begin
      tl = TILE_W'(1);
    end else if (tile_q > TILE_MAX) begin
      tl = TILE_MAX;
    end else begin
      tl = tile_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      tile_q <= TILE_RESET;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        tile_q <= cfg_data_i;
      end
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // heading normalize at capture
  logic signed [HEAD_W:0] h_sub, h_fix;
  always_comb begin
    h_sub = {heading_deg_i[HEAD_W-1], heading_deg_i};
    if (h_sub >= FULL_DEG) begin
      h_sub = h_sub - FULL_DEG;
    end
    h_fix = (h_sub < 0) ? h_sub + FULL_DEG : h_sub;
  end

  logic [POS_W-1:0]         px_w [IW+1];
  logic [POS_W-1:0]         py_w [IW+1];
  logic [TILE_W-1:0]        rx_w [IW+1];
  logic [TILE_W-1:0]        ry_w [IW+1];
  logic signed [HEAD_W:0]   h_q  [IW+1];
  logic signed [RAD_W-1:0]  rad_q [2:IW];
  logic [45:0]              prod_q;
  logic [POS_W-1:0]         px0_q, py0_q;

  always_ff @(posedge clk_i) begin
    px0_q  <= pos_x_i;
    py0_q  <= pos_y_i;
    h_q[0] <= h_fix;
  end
  assign px_w[0] = px0_q;
  assign py_w[0] = py0_q;
  assign rx_w[0] = '0;
  assign ry_w[0] = '0;

  genvar k;
  generate
    for (k = 0; k < IW; k++) begin : g_mod
      tcac_mod_cell #(.IDX(k)) u_mx (
        .clk_i(clk_i), .tile_i(tl), .pos_i(px_w[k]), .rem_i(rx_w[k]),
        .pos_o(px_w[k+1]), .rem_o(rx_w[k+1])
      );
      tcac_mod_cell #(.IDX(k)) u_my (
        .clk_i(clk_i), .tile_i(tl), .pos_i(py_w[k]), .rem_i(ry_w[k]),
        .pos_o(py_w[k+1]), .rem_o(ry_w[k+1])
      );
    end
  endgenerate

  // heading in radians alongside the remainder chain
  logic [HEAD_W-1:0] mag;
  logic [46:0]       rnd;
  logic [RAD_W-1:0]  r_mag;
  assign mag   = h_q[0][HEAD_W] ? HEAD_W'(-h_q[0]) : HEAD_W'(h_q[0]);
  assign rnd   = {1'b0, prod_q} + (47'd1 << (RS - 1));
  assign r_mag = RAD_W'(rnd >> RS);

  always_ff @(posedge clk_i) begin
    prod_q   <= 46'(mag) * 46'(DEG_TO_RAD_Q32);
    rad_q[2] <= h_q[1][HEAD_W] ? -$signed(r_mag) : $signed(r_mag);
    for (int i = 1; i <= IW; i++) begin
      h_q[i] <= h_q[i-1];
    end
    for (int i = 3; i <= IW; i++) begin
      rad_q[i] <= rad_q[i-1];
    end
  end

  // distances, border rule from the heading
  logic [DW-1:0] t_full, rx_full, ry_full;
  logic [DW-1:0] top_d, bot_d, left_d, right_d;
  logic [DW-1:0] top_q, bot_q, left_q, right_q;
  logic signed [HEAD_W:0] hs;
  assign t_full  = DW'(tl) << POS_FRAC_BITS;
  assign rx_full = (DW'(rx_w[IW]) << POS_FRAC_BITS) | DW'(px_w[IW] & FRAC_MASK);
  assign ry_full = (DW'(ry_w[IW]) << POS_FRAC_BITS) | DW'(py_w[IW] & FRAC_MASK);
  assign hs      = h_q[IW];

  always_comb begin
    if (ry_full == '0) begin
      top_d = (hs < HALF_DEG) ? t_full : '0;
      bot_d = (hs < HALF_DEG) ? '0 : t_full;
    end else begin
      top_d = ry_full;
      bot_d = t_full - ry_full;
    end
    if (rx_full == '0) begin
      left_d  = (hs < QUART_DEG || hs > THREEQ_DEG) ? '0 : t_full;
      right_d = (hs < QUART_DEG || hs > THREEQ_DEG) ? t_full : '0;
    end else begin
      left_d  = rx_full;
      right_d = t_full - rx_full;
    end
  end

  side_t sd_q [CORDIC_STAGES+1];

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    bot_q   <= bot_d;
    left_q  <= left_d;
    right_q <= right_d;
    sd_q[0].heading  <= h_q[IW][HEAD_W-1:0];
    sd_q[0].rad      <= rad_q[IW];
    sd_q[0].d_top    <= DIST_W'(top_d);
    sd_q[0].d_bot    <= DIST_W'(bot_d);
    sd_q[0].d_left   <= DIST_W'(left_d);
    sd_q[0].d_right  <= DIST_W'(right_d);
    sd_q[0].num_zero <= {right_d == '0, bot_d == '0, left_d == '0, top_d == '0};
    sd_q[0].den_zero <= {bot_d == '0, left_d == '0, top_d == '0, right_d == '0};
    for (int i = 1; i <= CORDIC_STAGES; i++) begin
      sd_q[i] <= sd_q[i-1];
    end
  end

  logic [DW-1:0] num [LANES];
  logic [DW-1:0] den [LANES];
  assign num[0] = top_q;   assign den[0] = right_q;
  assign num[1] = left_q;  assign den[1] = top_q;
  assign num[2] = bot_q;   assign den[2] = left_q;
  assign num[3] = right_q; assign den[3] = bot_q;

  logic signed [ZW-1:0]    z_fin [LANES];
  logic [ANG_W-1:0]        ang_d [LANES];

  genvar l, j;
  generate
    for (l = 0; l < LANES; l++) begin : g_lane
      logic signed [XW-1:0] xw [CORDIC_STAGES+1];
      logic signed [XW-1:0] yw [CORDIC_STAGES+1];
      logic signed [ZW-1:0] zw [CORDIC_STAGES+1];
      assign xw[0] = $signed(XW'(den[l]) << CORDIC_GUARD);
      assign yw[0] = $signed(XW'(num[l]) << CORDIC_GUARD);
      assign zw[0] = '0;
      for (j = 0; j < CORDIC_STAGES; j++) begin : g_cell
        tcac_cordic_cell #(.IDX(j), .XW(XW)) u_cell (
          .clk_i(clk_i), .x_i(xw[j]), .y_i(yw[j]), .z_i(zw[j]),
          .x_o(xw[j+1]), .y_o(yw[j+1]), .z_o(zw[j+1])
        );
      end
      assign z_fin[l] = zw[CORDIC_STAGES];

      logic signed [ZW-1:0] zc;
      logic [ZW-1:0]        sum;
      always_comb begin
        if (sd_q[CORDIC_STAGES].num_zero[l]) begin
          zc = '0;
        end else if (sd_q[CORDIC_STAGES].den_zero[l]) begin
          zc = QUARTER_Q32;
        end else if (z_fin[l] < 0) begin
          zc = '0;
        end else if (z_fin[l] > QUARTER_Q32) begin
          zc = QUARTER_Q32;
        end else begin
          zc = z_fin[l];
        end
        sum      = $unsigned(zc) + QUAD_OFF[l] + (ZW'(1) << (AS - 1));
        ang_d[l] = ANG_W'(sum >> AS);
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    heading_norm_o       <= sd_q[CORDIC_STAGES].heading;
    heading_rad_o        <= sd_q[CORDIC_STAGES].rad;
    dist_top_o           <= sd_q[CORDIC_STAGES].d_top;
    dist_bottom_o        <= sd_q[CORDIC_STAGES].d_bot;
    dist_left_o          <= sd_q[CORDIC_STAGES].d_left;
    dist_right_o         <= sd_q[CORDIC_STAGES].d_right;
    angle_top_right_o    <= ang_d[0];
    angle_top_left_o     <= ang_d[1];
    angle_bottom_left_o  <= ang_d[2];
    angle_bottom_right_o <= ang_d[3];
  end

  `ASSERT_IMPL(a_latency, start && !busy, ##LAT done_o, "beat lost in pipeline")
  `ASSERT_AT(a_busy_stays_low, !busy |=> !busy, "busy rose after reset release")
  `ASSERT_IMPL(a_angle_range, done_o,
    angle_top_right_o <= ANGLE_MAX && angle_top_left_o <= ANGLE_MAX &&
    angle_bottom_left_o <= ANGLE_MAX && angle_bottom_right_o <= ANGLE_MAX,
    "corner angle above full turn")
endmodule

>>> bench/tile_corner_angle_calc_test.sv
`timescale 1ns / 100ps
// Self-checking bench for tile_corner_angle_calc: directed rows, then random
// positions and headings over several tile lengths. Depends on tcac_pkg.
module tile_corner_angle_calc_test;
  import tcac_pkg::*;

  localparam int LATENCY = 40;
  localparam int STALL_LIMIT = 5000;
  localparam longint FULL = 92160;
  localparam longint QUARTER = 64'd6746518852;
  localparam longint HALF = 64'd13493037704;
  localparam longint THREEQ = 64'd20239556557;

  typedef struct {
    logic [HEAD_W-1:0] hnorm;
    logic [RAD_W-1:0] rad;
    logic [DIST_W-1:0] top, bot, left, right;
    logic [ANG_W-1:0] a_tr, a_tl, a_bl, a_br;
  } corner_res_t;

  typedef struct {
    logic [POS_W-1:0] px, py;
    logic [HEAD_W-1:0] hd;
    bit typed;
    logic [HEAD_W-1:0] hnorm;
    logic [DIST_W-1:0] top, bot;
  } dir_row_t;

  logic clk_i = 0, rst_ni = 0;
  logic start = 0, cfg_valid_i = 0;
  logic [TILE_W-1:0] cfg_data_i = '0;
  logic [POS_W-1:0] pos_x_i = '0, pos_y_i = '0;
  logic signed [HEAD_W-1:0] heading_deg_i = '0;
  logic busy, cfg_ready_o, done_o;
  logic signed [HEAD_W-1:0] heading_norm_o;
  logic signed [RAD_W-1:0] heading_rad_o;
  logic [DIST_W-1:0] dist_top_o, dist_bottom_o, dist_left_o, dist_right_o;
  logic [ANG_W-1:0] angle_top_right_o, angle_top_left_o;
  logic [ANG_W-1:0] angle_bottom_left_o, angle_bottom_right_o;

  corner_res_t pending_q[$];
  longint tile_cfg = 64;
  int errors = 0;
  int stall_cnt = 0;
  int idle_pct = 0;

  tile_corner_angle_calc u_top (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  const longint atan_lut[16] = '{
    64'd3373259426, 1991351318, 1052175346, 534100635, 268086748, 134174063,
    67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576,
    524288, 262144, 131072
  };

  function automatic longint cordic_atan(longint num, longint den);
    longint x, y, z, dx, dy;
    z = 0;
    if (num == 0) return 0;
    if (den == 0) return QUARTER;
    x = den <<< 24;
    y = num <<< 24;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER) z = QUARTER;
    return z;
  endfunction

  function automatic logic [ANG_W-1:0] round_angle(longint q32);
    longint v;
    v = (q32 + 64'd32768) >> 16;
    return v[ANG_W-1:0];
  endfunction

  function automatic corner_res_t predict_corners(logic [POS_W-1:0] px,
      logic [POS_W-1:0] py, logic signed [HEAD_W-1:0] hd);
    corner_res_t r;
    longint h, mag, rr, rad, tl, t, rx, ry, top, bot, left, right;
    h = hd;
    if (h >= FULL) h -= FULL;
    if (h < 0) h += FULL;
    mag = h < 0 ? -h : h;
    rr = (mag * 64'd74961321 + (64'd1 << 23)) >> 24;
    rad = h < 0 ? -rr : rr;
    tl = tile_cfg;
    if (tl == 0) tl = 1;
    if (tl > 1024) tl = 1024;
    t = tl << 8;
    ry = longint'(py) % t;
    rx = longint'(px) % t;
    if (ry == 0) begin
      top = h < 46080 ? t : 0;
      bot = h < 46080 ? 0 : t;
    end else begin
      top = ry; bot = t - ry;
    end
    if (rx == 0) begin
      left = (h < 23040 || h > 69120) ? 0 : t;
      right = (h < 23040 || h > 69120) ? t : 0;
    end else begin
      left = rx; right = t - rx;
    end
    r.hnorm = h[HEAD_W-1:0];
    r.rad = rad[RAD_W-1:0];
    r.top = top[DIST_W-1:0];
    r.bot = bot[DIST_W-1:0];
    r.left = left[DIST_W-1:0];
    r.right = right[DIST_W-1:0];
    r.a_tr = round_angle(cordic_atan(top, right));
    r.a_tl = round_angle(cordic_atan(left, top) + QUARTER);
    r.a_bl = round_angle(cordic_atan(bot, left) + HALF);
    r.a_br = round_angle(cordic_atan(right, bot) + THREEQ);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    corner_res_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (heading_norm_o !== e.hnorm) report_mismatch("heading_norm", heading_norm_o, e.hnorm);
        if (heading_rad_o !== e.rad) report_mismatch("heading_rad", heading_rad_o, e.rad);
        if (dist_top_o !== e.top) report_mismatch("dist_top", dist_top_o, e.top);
        if (dist_bottom_o !== e.bot) report_mismatch("dist_bottom", dist_bottom_o, e.bot);
        if (dist_left_o !== e.left) report_mismatch("dist_left", dist_left_o, e.left);
        if (dist_right_o !== e.right) report_mismatch("dist_right", dist_right_o, e.right);
        if (angle_top_right_o !== e.a_tr)
          report_mismatch("angle_top_right", angle_top_right_o, e.a_tr);
        if (angle_top_left_o !== e.a_tl)
          report_mismatch("angle_top_left", angle_top_left_o, e.a_tl);
        if (angle_bottom_left_o !== e.a_bl)
          report_mismatch("angle_bottom_left", angle_bottom_left_o, e.a_bl);
        if (angle_bottom_right_o !== e.a_br)
          report_mismatch("angle_bottom_right", angle_bottom_right_o, e.a_br);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
      logic [HEAD_W-1:0] hd, output corner_res_t pred);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    heading_deg_i <= hd;
    do @(posedge clk_i); while (busy);
    pred = predict_corners(px, py, hd);
    pending_q.push_back(pred);
  endtask

  task automatic write_tile_len(logic [TILE_W-1:0] v);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tile_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    corner_res_t p;
    logic [POS_W-1:0] px, py;
    logic [HEAD_W-1:0] hd;
    longint t;
    t = (tile_cfg == 0 ? 1 : (tile_cfg > 1024 ? 1024 : tile_cfg)) << 8;
    for (int i = 0; i < n; i++) begin
      px = POS_W'($urandom);
      py = POS_W'($urandom);
      if ($urandom_range(99) < 25) px = POS_W'(($urandom % ((64'd1 << 24) / t)) * t);
      if ($urandom_range(99) < 25) py = POS_W'(($urandom % ((64'd1 << 24) / t)) * t);
      if ($urandom_range(99) < 75) hd = HEAD_W'($urandom_range(92159));
      else hd = HEAD_W'($urandom);
      if ($urandom_range(99) < 10)
        hd = HEAD_W'(($urandom_range(3) * 23040) + $urandom_range(2) - 1);
      send_item(px, py, hd, p);
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{24'd0, 24'd0, 19'd0, 1, 19'd0, 19'd16384, 19'd0},
    '{24'd0, 24'd0, 19'd46080, 1, 19'd46080, 19'd0, 19'd16384},
    '{24'd0, 24'd0, 19'd23040, 1, 19'd23040, 19'd16384, 19'd0},
    '{24'd0, 24'd0, 19'd69120, 1, 19'd69120, 19'd0, 19'd16384},
    '{24'd0, 24'd0, 19'd23039, 0, 0, 0, 0},
    '{24'd0, 24'd0, 19'd69121, 0, 0, 0, 0},
    '{24'd0, 24'd0, 19'd46079, 0, 0, 0, 0},
    '{24'd16384, 24'd16384, 19'd92160, 1, 19'd0, 19'd16384, 19'd0},
    '{24'd1, 24'd1, 19'h7FFFF, 1, 19'd92159, 19'd1, 19'd16383},
    '{24'hFFFFFF, 24'hFFFFFF, 19'd184319, 1, 19'd92159, 19'd16383, 19'd1},
    '{24'd8192, 24'd8192, 19'h69800, 1, 19'd0, 19'd8192, 19'd8192},
    '{24'd100, 24'd0, 19'h40000, 0, 0, 0, 0},
    '{24'd0, 24'd100, 19'h3FFFF, 0, 0, 0, 0},
    '{24'hAAAAAA, 24'h555555, 19'h2AAAA, 0, 0, 0, 0},
    '{24'h555555, 24'hAAAAAA, 19'h55555, 0, 0, 0, 0},
    '{24'd0, 24'd5, 19'd1000, 0, 0, 0, 0},
    '{24'd5, 24'd0, 19'd60000, 0, 0, 0, 0}
  };

  initial begin
    corner_res_t p;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].px, dir_rows[i].py, dir_rows[i].hd, p);
      if (dir_rows[i].typed) begin
        p.hnorm = dir_rows[i].hnorm;
        p.top = dir_rows[i].top;
        p.bot = dir_rows[i].bot;
        pending_q[$] = p;
      end
    end
    idle_pct = 8;
    random_phase(250);
    write_tile_len(11'd1);
    random_phase(250);
    write_tile_len(11'd1024);
    idle_pct = 51;
    random_phase(250);
    write_tile_len(11'd0);
    random_phase(200);
    write_tile_len(11'd2047);
    idle_pct = 0;
    random_phase(200);
    write_tile_len(11'($urandom_range(1, 1023)));
    random_phase(300);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
